FILE: rtl/core/prss_pkg.sv
// ============================================================================
// prss_pkg
// Shared types and constants for the Pascal row square-sum core: memory
// geometry, microcode control word layout and datapath status flags.
// ============================================================================
package prss_pkg;

    // Row store geometry.
    localparam int ROW_DEPTH = 64;
    localparam int IDX_W     = $clog2(ROW_DEPTH);
    localparam int PASS_W    = IDX_W + 1;
    localparam int ROW_IN_W  = 6;
    localparam int DATA_W    = 64;
    localparam int HALF_W    = DATA_W / 2;
    localparam int UPC_W     = 4;

    typedef logic [UPC_W-1:0] t_upc;

    // Microcode addresses.
    localparam t_upc UPC_IDLE   = t_upc'(0);
    localparam t_upc UPC_FILL   = t_upc'(1);
    localparam t_upc UPC_PSTART = t_upc'(2);
    localparam t_upc UPC_PRD2   = t_upc'(3);
    localparam t_upc UPC_INNER  = t_upc'(4);
    localparam t_upc UPC_PNEXT  = t_upc'(5);
    localparam t_upc UPC_SQINIT = t_upc'(6);
    localparam t_upc UPC_SQRD   = t_upc'(7);
    localparam t_upc UPC_SQM0   = t_upc'(8);
    localparam t_upc UPC_SQM1   = t_upc'(9);
    localparam t_upc UPC_SQM2   = t_upc'(10);
    localparam t_upc UPC_DONE   = t_upc'(11);

    // Jump condition: when it holds the sequencer goes to the target,
    // otherwise it falls through to the next step.
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_START,
        COND_J_NE_N,
        COND_P_GT_N,
        COND_J_NE_1
    } t_cond;

    typedef enum logic [2:0] {
        J_HOLD,
        J_INC,
        J_DEC,
        J_CLEAR,
        J_LOAD_PM1
    } t_jop;

    typedef enum logic {
        P_HOLD,
        P_INC
    } t_pop;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_J,
        RD_JM1,
        RD_JM2,
        RD_JP1,
        RD_PM1
    } t_rdsel;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_ONE,
        WR_SUM
    } t_wrsel;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_ADD_SQ,
        ACC_ADD_CROSS
    } t_accop;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_LOLO,
        MUL_LOHI
    } t_mulsel;

    // One microcode control word.
    typedef struct packed {
        t_cond   cond;
        t_upc    target;
        t_jop    jop;
        t_pop    pop;
        t_rdsel  rdsel;
        t_wrsel  wrsel;
        logic    a_load;
        t_accop  accop;
        t_mulsel mulsel;
        logic    strobe;
    } t_uword;

    // Datapath flags tested by the jump conditions.
    typedef struct packed {
        logic j_ne_n;
        logic p_gt_n;
        logic j_ne_1;
    } t_status;

endpackage

FILE: rtl/core/prss_datapath.sv
// ============================================================================
// prss_datapath
// Row store memory, index and pass counters, neighbor adder, shared 32x32
// multiplier and square accumulator, all steered by the microcode word.
// ============================================================================
module prss_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  logic [prss_pkg::ROW_IN_W-1:0]  i_row_index,
    input  prss_pkg::t_uword               i_uword,
    output prss_pkg::t_status              o_status,
    output logic [prss_pkg::DATA_W-1:0]    o_acc
);

    logic [prss_pkg::DATA_W-1:0]  r_row_mem [prss_pkg::ROW_DEPTH];
    logic [prss_pkg::IDX_W-1:0]   r_n, n_n;
    logic [prss_pkg::IDX_W-1:0]   r_j, n_j;
    logic [prss_pkg::PASS_W-1:0]  r_p, n_p;
    logic [prss_pkg::DATA_W-1:0]  r_a, n_a;
    logic [prss_pkg::DATA_W-1:0]  r_rd;
    logic [prss_pkg::DATA_W-1:0]  r_prod;
    logic [prss_pkg::DATA_W-1:0]  r_acc, n_acc;

    logic [prss_pkg::IDX_W-1:0]   rd_addr;
    logic                         rd_en;
    logic                         wr_en;
    logic [prss_pkg::DATA_W-1:0]  wr_data;
    logic [prss_pkg::HALF_W-1:0]  mul_b;
    logic                         mul_en;
    logic [prss_pkg::IDX_W-1:0]   row_sat;

    // Clamp the requested row to the last row the store can hold.
    always_comb begin
        if (32'(i_row_index) > 32'(prss_pkg::ROW_DEPTH - 1)) begin
            row_sat = prss_pkg::IDX_W'(prss_pkg::ROW_DEPTH - 1);
        end else begin
            row_sat = prss_pkg::IDX_W'(i_row_index);
        end
    end

    // Read address selection.
    always_comb begin
        rd_en   = 1'b1;
        rd_addr = r_j;
        case (i_uword.rdsel)
            prss_pkg::RD_NONE: rd_en   = 1'b0;
            prss_pkg::RD_J:    rd_addr = r_j;
            prss_pkg::RD_JM1:  rd_addr = r_j - prss_pkg::IDX_W'(1);
            prss_pkg::RD_JM2:  rd_addr = r_j - prss_pkg::IDX_W'(2);
            prss_pkg::RD_JP1:  rd_addr = r_j + prss_pkg::IDX_W'(1);
            prss_pkg::RD_PM1:  rd_addr = r_p[prss_pkg::IDX_W-1:0] - prss_pkg::IDX_W'(1);
            default:           rd_en   = 1'b0;
        endcase
    end

    // Write data selection: a fill with ones or the neighbor sum.
    always_comb begin
        wr_en   = 1'b1;
        wr_data = r_a + r_rd;
        case (i_uword.wrsel)
            prss_pkg::WR_NONE: wr_en   = 1'b0;
            prss_pkg::WR_ONE:  wr_data = prss_pkg::DATA_W'(1);
            prss_pkg::WR_SUM:  wr_data = r_a + r_rd;
            default:           wr_en   = 1'b0;
        endcase
    end

    // Row store: one write port at the current index, one registered read.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_row_mem[r_j] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_row_mem[rd_addr];
        end
    end

    // Index, pass and held-neighbor registers.
    always_comb begin
        n_n = r_n;
        n_j = r_j;
        n_p = r_p;
        n_a = i_uword.a_load ? r_rd : r_a;
        case (i_uword.jop)
            prss_pkg::J_HOLD:     n_j = r_j;
            prss_pkg::J_INC:      n_j = r_j + prss_pkg::IDX_W'(1);
            prss_pkg::J_DEC:      n_j = r_j - prss_pkg::IDX_W'(1);
            prss_pkg::J_CLEAR:    n_j = '0;
            prss_pkg::J_LOAD_PM1: n_j = r_p[prss_pkg::IDX_W-1:0] - prss_pkg::IDX_W'(1);
            default:              n_j = r_j;
        endcase
        if (i_uword.pop == prss_pkg::P_INC) begin
            n_p = r_p + prss_pkg::PASS_W'(1);
        end
        // A new transaction starts the fill at index zero and the passes at two.
        if (i_load) begin
            n_n = row_sat;
            n_j = '0;
            n_p = prss_pkg::PASS_W'(2);
        end
    end

    always_ff @(posedge i_clk) begin
        r_n <= n_n;
        r_j <= n_j;
        r_p <= n_p;
        r_a <= n_a;
    end

    // Shared multiplier: low half times low half, then low half times high half.
    always_comb begin
        mul_en = 1'b1;
        mul_b  = r_rd[prss_pkg::HALF_W-1:0];
        case (i_uword.mulsel)
            prss_pkg::MUL_NONE: mul_en = 1'b0;
            prss_pkg::MUL_LOLO: mul_b  = r_rd[prss_pkg::HALF_W-1:0];
            prss_pkg::MUL_LOHI: mul_b  = r_rd[prss_pkg::DATA_W-1:prss_pkg::HALF_W];
            default:            mul_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= prss_pkg::DATA_W'(r_rd[prss_pkg::HALF_W-1:0]) * prss_pkg::DATA_W'(mul_b);
        end
    end

    // Square accumulator. Modulo 2^64, x*x = lo*lo + (lo*hi << 33).
    always_comb begin
        n_acc = r_acc;
        case (i_uword.accop)
            prss_pkg::ACC_HOLD:      n_acc = r_acc;
            prss_pkg::ACC_ADD_SQ:    n_acc = r_acc + r_prod;
            prss_pkg::ACC_ADD_CROSS: n_acc = r_acc +
                {r_prod[prss_pkg::HALF_W-2:0], {(prss_pkg::HALF_W+1){1'b0}}};
            default:                 n_acc = r_acc;
        endcase
        if (i_load) begin
            n_acc = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

    // Flags for the sequencer.
    always_comb begin
        o_status.j_ne_n = (r_j != r_n);
        o_status.p_gt_n = (r_p > {1'b0, r_n});
        o_status.j_ne_1 = (r_j != prss_pkg::IDX_W'(1));
    end

    assign o_acc = r_acc;

endmodule

FILE: rtl/core/prss_useq.sv
// ============================================================================
// prss_useq
// Microcode sequencer: a step counter, the control store and the jump logic.
// It also registers the result strobe.
// ============================================================================
module prss_useq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  prss_pkg::t_status  i_status,
    output prss_pkg::t_uword   o_uword,
    output logic               o_busy,
    output logic               o_valid
);

    prss_pkg::t_upc   r_upc, n_upc;
    logic             r_valid;
    prss_pkg::t_uword uword;
    logic             take;

    // Control store.
    function automatic prss_pkg::t_uword rom_word(input prss_pkg::t_upc pc);
        prss_pkg::t_uword w;
        w.cond   = prss_pkg::COND_NEVER;
        w.target = prss_pkg::UPC_IDLE;
        w.jop    = prss_pkg::J_HOLD;
        w.pop    = prss_pkg::P_HOLD;
        w.rdsel  = prss_pkg::RD_NONE;
        w.wrsel  = prss_pkg::WR_NONE;
        w.a_load = 1'b0;
        w.accop  = prss_pkg::ACC_HOLD;
        w.mulsel = prss_pkg::MUL_NONE;
        w.strobe = 1'b0;
        case (pc)
            prss_pkg::UPC_IDLE: begin
                w.cond   = prss_pkg::COND_NO_START;
                w.target = prss_pkg::UPC_IDLE;
            end
            // Fill entries 0..n with ones.
            prss_pkg::UPC_FILL: begin
                w.wrsel  = prss_pkg::WR_ONE;
                w.jop    = prss_pkg::J_INC;
                w.cond   = prss_pkg::COND_J_NE_N;
                w.target = prss_pkg::UPC_FILL;
            end
            // Open a pass: index to p-1, fetch that entry.
            prss_pkg::UPC_PSTART: begin
                w.jop    = prss_pkg::J_LOAD_PM1;
                w.rdsel  = prss_pkg::RD_PM1;
                w.cond   = prss_pkg::COND_P_GT_N;
                w.target = prss_pkg::UPC_SQINIT;
            end
            prss_pkg::UPC_PRD2: begin
                w.rdsel  = prss_pkg::RD_JM1;
                w.a_load = 1'b1;
            end
            // Entry j gets entry j-1 added; the old j-1 is carried to the next step.
            prss_pkg::UPC_INNER: begin
                w.wrsel  = prss_pkg::WR_SUM;
                w.a_load = 1'b1;
                w.rdsel  = prss_pkg::RD_JM2;
                w.jop    = prss_pkg::J_DEC;
                w.cond   = prss_pkg::COND_J_NE_1;
                w.target = prss_pkg::UPC_INNER;
            end
            prss_pkg::UPC_PNEXT: begin
                w.pop    = prss_pkg::P_INC;
                w.cond   = prss_pkg::COND_ALWAYS;
                w.target = prss_pkg::UPC_PSTART;
            end
            prss_pkg::UPC_SQINIT: begin
                w.jop    = prss_pkg::J_CLEAR;
            end
            prss_pkg::UPC_SQRD: begin
                w.rdsel  = prss_pkg::RD_J;
            end
            prss_pkg::UPC_SQM0: begin
                w.mulsel = prss_pkg::MUL_LOLO;
            end
            prss_pkg::UPC_SQM1: begin
                w.accop  = prss_pkg::ACC_ADD_SQ;
                w.mulsel = prss_pkg::MUL_LOHI;
                w.rdsel  = prss_pkg::RD_JP1;
            end
            prss_pkg::UPC_SQM2: begin
                w.accop  = prss_pkg::ACC_ADD_CROSS;
                w.jop    = prss_pkg::J_INC;
                w.cond   = prss_pkg::COND_J_NE_N;
                w.target = prss_pkg::UPC_SQM0;
            end
            prss_pkg::UPC_DONE: begin
                w.strobe = 1'b1;
                w.cond   = prss_pkg::COND_ALWAYS;
                w.target = prss_pkg::UPC_IDLE;
            end
            default: begin
                w.cond   = prss_pkg::COND_ALWAYS;
                w.target = prss_pkg::UPC_IDLE;
            end
        endcase
        return w;
    endfunction

    assign uword = rom_word(r_upc);

    // Jump condition evaluation and next step.
    always_comb begin
        case (uword.cond)
            prss_pkg::COND_NEVER:    take = 1'b0;
            prss_pkg::COND_ALWAYS:   take = 1'b1;
            prss_pkg::COND_NO_START: take = !i_start;
            prss_pkg::COND_J_NE_N:   take = i_status.j_ne_n;
            prss_pkg::COND_P_GT_N:   take = i_status.p_gt_n;
            prss_pkg::COND_J_NE_1:   take = i_status.j_ne_1;
            default:                 take = 1'b1;
        endcase
        n_upc = take ? uword.target : r_upc + prss_pkg::t_upc'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc   <= prss_pkg::UPC_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_upc   <= n_upc;
            r_valid <= uword.strobe;
        end
    end

    assign o_uword = uword;
    assign o_busy  = (r_upc != prss_pkg::UPC_IDLE);
    assign o_valid = r_valid;

endmodule

FILE: rtl/core/pascal_row_square_sum_core.sv
// Timing: the wait from the accepting edge to o_valid grows with the row n and
// is set by the in-place pass loop over the row store and the three-step
// multiply per entry.
// Throughput: one transaction at a time; busy stays high until the result.
// Reset: synchronous, active low; the sequencer returns to idle, the strobe
// and accumulator clear. The receiver cannot stall the result.
// ============================================================================
// pascal_row_square_sum_core
// Sum of the squared binomial coefficients of one Pascal row, built in place
// in a row store and accumulated modulo 2^64 by a microcoded sequencer.
// ============================================================================
module pascal_row_square_sum_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [prss_pkg::ROW_IN_W-1:0] i_row_index,
    output logic                          o_valid,
    output logic [prss_pkg::DATA_W-1:0]   o_square_sum
);

    prss_pkg::t_uword  uword;
    prss_pkg::t_status status;
    logic              load;

    // A transaction is taken only while the sequencer sits idle.
    assign load = start && !busy;

    prss_useq u_useq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_uword  (uword),
        .o_busy   (busy),
        .o_valid  (o_valid)
    );

    prss_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_row_index (i_row_index),
        .i_uword     (uword),
        .o_status    (status),
        .o_acc       (o_square_sum)
    );

endmodule

FILE: rtl/core/prss_checker.sv
// ============================================================================
// prss_checker
// Port-level checks of the start/busy command handshake and the result strobe.
// ============================================================================
module prss_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_valid,
    input logic [prss_pkg::DATA_W-1:0] o_square_sum
);

    // An accepted transaction makes the core busy on the next cycle.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // The result is shown only once the core is idle again.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // Busy only drops together with a result.
    a_busy_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("busy dropped without a result");

    // Each result strobe lasts one cycle.
    a_one_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // Every square sum of a Pascal row is odd-or-even per C(2n,n); it is never zero
    // below wrap, and row zero gives one: the strobe never shows the reset zero.
    a_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_square_sum != '0))
        else $error("result strobe with zero sum");

endmodule

bind pascal_row_square_sum_core prss_checker u_prss_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_square_sum (o_square_sum)
);
